// ===== design/rmd_pkg.sv =====
// Shared types and constants for the RPC message deframer.
// Used by rmd_parser, rmd_queue and rpc_message_deframer; depends on nothing.
`timescale 1ns / 1ps

package rmd_pkg;

    // Header layout and classification constants.
    localparam int unsigned HDR_BYTES    = 20;
    localparam int unsigned PREFIX_BYTES = 6;
    localparam logic [31:0] TXID_BASE    = 32'h1100_0100;
    localparam logic [31:0] TXID_MASK    = 32'hFFFF_FF00;
    localparam logic [31:0] ACK_CODE_MIN = 32'd2000;

    // Result queue sizing.
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QPTR_W      = 3;
    localparam int unsigned QLVL_W      = 4;

    // Result item kinds.
    localparam logic KIND_BODY   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Message classes.
    localparam logic [1:0] MSG_RESPONSE    = 2'd0;
    localparam logic [1:0] MSG_ASYNC_ACK   = 2'd1;
    localparam logic [1:0] MSG_UNSOLICITED = 2'd2;

    // End-of-read status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // One result word.
    typedef struct packed {
        logic        item_kind;
        logic [7:0]  body_byte;
        logic [1:0]  message_type;
        logic [31:0] message_code;
        logic [31:0] transaction_id;
        logic [1:0]  status;
        logic [14:0] body_length;
        logic        last;
    } result_t;

    // Up to two results produced by one input byte.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== design/rpc_message_deframer.sv =====
// Top level of the RPC message deframer: byte stream in, body and status words out.
// Depends on rmd_pkg, rmd_parser and rmd_queue.
`timescale 1ns / 1ps

// Usage:
// The slave stream carries the bytes of one device read, one byte per word,
// with tlast on the final byte of the read. The master stream returns body
// bytes (tuser 0) and, at the end of each read, one status word (tuser 1,
// tlast 1) with the message class, header code, transaction word, status
// and the number of body bytes delivered.
// A byte taken is held in the input register, evaluated against the header
// state and written into an eight-word result queue, from which its results
// can leave. One byte is accepted every cycle while s_tready is high; a byte
// that ends the read may add a second word, so the output side sets the
// sustained rate when reads are short. When the receiver stalls, the queue
// fills and s_tready drops once fewer than two free places remain, or four
// while a byte is held in the input register. Reset clears the header state,
// the input register and the queue; no stored word survives it.

module rpc_message_deframer #(
    parameter int unsigned MAX_READ_BYTES = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_read
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [7:0] body_byte, [9:8] message_type,
                                   // [41:10] message_code, [73:42] transaction_id,
                                   // [75:74] status, [90:76] body_length, rest zero
    output logic        m_tuser,   // item_kind
    output logic        m_tlast    // last
);

    rmd_pkg::push_t                push;
    rmd_pkg::result_t              head;
    logic [rmd_pkg::QLVL_W-1:0]    level;

    rmd_parser #(
        .MAX_READ_BYTES (MAX_READ_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_byte     (s_tdata),
        .in_eor      (s_tlast),
        .queue_level (level),
        .in_ready    (s_tready),
        .push        (push)
    );

    rmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (m_tready),
        .head      (head),
        .not_empty (m_tvalid),
        .level     (level)
    );

    // Output word packing.
    assign m_tdata = {5'b0, head.body_length, head.status, head.transaction_id,
                      head.message_code, head.message_type, head.body_byte};
    assign m_tuser = head.item_kind;
    assign m_tlast = head.last;

    // The queue never holds more than its depth.
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= rmd_pkg::QLVL_W'(rmd_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // A word leaving with tlast is always a status word.
    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == rmd_pkg::KIND_STATUS)
        else $error("tlast on a body word");

    // Body words carry nothing beside the byte.
    a_body_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == rmd_pkg::KIND_BODY |-> m_tdata[95:8] == '0 && !m_tlast)
        else $error("body word carries status fields");

    // Two words pushed in one cycle are a body byte followed by a status word.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> push.first.item_kind == rmd_pkg::KIND_BODY
                               && push.second.item_kind == rmd_pkg::KIND_STATUS)
        else $error("bad result pair order");

endmodule

// ===== design/rmd_parser.sv =====
// Header capture, body trimming and status generation for one byte per cycle while in_ready is high.
// Depends on rmd_pkg; feeds its results into rmd_queue.
`timescale 1ns / 1ps

module rmd_parser #(
    parameter int unsigned MAX_READ_BYTES = 16384
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [7:0]                  in_byte,
    input  logic                        in_eor,
    input  logic [rmd_pkg::QLVL_W-1:0]  queue_level,
    output logic                        in_ready,
    output rmd_pkg::push_t              push
);

    localparam int unsigned IW = $clog2(MAX_READ_BYTES + 1);
    localparam int unsigned CW = (IW > 15) ? IW : 15;

    // Input register.
    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_eor_reg;

    // Per-read state.
    logic [IW-1:0] byte_index_reg, byte_index_next;
    logic [31:0]   declared_reg, declared_next;
    logic [31:0]   code_reg, code_next;
    logic [31:0]   txid_reg, txid_next;
    logic          strip_reg, strip_next;
    logic [CW-1:0] body_count_reg, body_count_next;

    logic          active;
    logic          async_resp;
    logic          emit_body;
    logic [32:0]   frame_size;
    logic [32:0]   frame_size_end;
    logic [32:0]   idx_wide;
    logic [32:0]   count_wide;
    logic [1:0]    st;
    logic [1:0]    mtype;
    rmd_pkg::result_t body_res;
    rmd_pkg::result_t stat_res;

    // Accept a byte only when the queue can take both results of it and of the one in flight.
    assign in_ready = ({1'b0, queue_level} + {3'b000, hold_valid_reg, 1'b0})
                      <= 5'(rmd_pkg::QUEUE_DEPTH - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= in_valid && in_ready;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_byte_reg <= in_byte;
            hold_eor_reg  <= in_eor;
        end
    end

    // Header capture and body decision for the held byte.
    always_comb
    begin
        active          = byte_index_reg < IW'(MAX_READ_BYTES);
        declared_next   = declared_reg;
        code_next       = code_reg;
        txid_next       = txid_reg;
        strip_next      = strip_reg;
        byte_index_next = byte_index_reg;
        body_count_next = body_count_reg;
        emit_body       = 1'b0;
        async_resp      = 1'b0;
        frame_size      = {1'b0, declared_reg} + 33'd4;
        idx_wide        = 33'(byte_index_reg);

        if (active)
        begin
            // Little-endian length word in bytes 0 to 3.
            if (byte_index_reg < IW'(4))
            begin
                case (byte_index_reg[1:0])
                    2'd0:    declared_next[7:0]   = hold_byte_reg;
                    2'd1:    declared_next[15:8]  = hold_byte_reg;
                    2'd2:    declared_next[23:16] = hold_byte_reg;
                    default: declared_next[31:24] = hold_byte_reg;
                endcase
            end
            else if (byte_index_reg >= IW'(12) && byte_index_reg < IW'(16))
            begin
                code_next = {code_reg[23:0], hold_byte_reg};
            end
            else if (byte_index_reg >= IW'(16) && byte_index_reg < IW'(rmd_pkg::HDR_BYTES))
            begin
                txid_next = {txid_reg[23:0], hold_byte_reg};
            end

            // On the last header byte decide whether a transaction prefix is stripped.
            if (byte_index_reg == IW'(rmd_pkg::HDR_BYTES - 1))
            begin
                async_resp = (txid_next != rmd_pkg::TXID_BASE)
                          && ((txid_next & rmd_pkg::TXID_MASK) == rmd_pkg::TXID_BASE)
                          && (code_next < rmd_pkg::ACK_CODE_MIN);
                strip_next = async_resp
                          && (frame_size >= 33'(rmd_pkg::HDR_BYTES + rmd_pkg::PREFIX_BYTES));
            end

            // Body bytes run from the body start up to the declared size.
            emit_body = (byte_index_reg >= IW'(rmd_pkg::HDR_BYTES))
                     && (!strip_reg
                         || byte_index_reg >= IW'(rmd_pkg::HDR_BYTES + rmd_pkg::PREFIX_BYTES))
                     && (idx_wide < frame_size);
            if (emit_body)
            begin
                body_count_next = body_count_reg + CW'(1);
            end
            byte_index_next = byte_index_reg + IW'(1);
        end
    end

    // End-of-read status from the updated state.
    always_comb
    begin
        frame_size_end = {1'b0, declared_next} + 33'd4;
        count_wide     = 33'(byte_index_next);
        if (byte_index_next < IW'(rmd_pkg::HDR_BYTES))
        begin
            st = rmd_pkg::ST_SHORT;
        end
        else if (frame_size_end < 33'(rmd_pkg::HDR_BYTES))
        begin
            st = rmd_pkg::ST_BAD_SIZE;
        end
        else if (frame_size_end > count_wide)
        begin
            st = rmd_pkg::ST_TRUNCATED;
        end
        else
        begin
            st = rmd_pkg::ST_OK;
        end

        if (txid_next == rmd_pkg::TXID_BASE)
        begin
            mtype = rmd_pkg::MSG_RESPONSE;
        end
        else if ((txid_next & rmd_pkg::TXID_MASK) == rmd_pkg::TXID_BASE)
        begin
            mtype = (code_next >= rmd_pkg::ACK_CODE_MIN) ? rmd_pkg::MSG_ASYNC_ACK
                                                         : rmd_pkg::MSG_RESPONSE;
        end
        else
        begin
            mtype = rmd_pkg::MSG_UNSOLICITED;
        end
    end

    // Build the result words.
    always_comb
    begin
        body_res           = '0;
        body_res.item_kind = rmd_pkg::KIND_BODY;
        body_res.body_byte = hold_byte_reg;

        stat_res                = '0;
        stat_res.item_kind      = rmd_pkg::KIND_STATUS;
        stat_res.message_type   = (st == rmd_pkg::ST_OK) ? mtype : rmd_pkg::MSG_RESPONSE;
        stat_res.message_code   = (st == rmd_pkg::ST_OK) ? code_next : 32'd0;
        stat_res.transaction_id = (st == rmd_pkg::ST_OK) ? txid_next : 32'd0;
        stat_res.status         = st;
        stat_res.body_length    = body_count_next[14:0];
        stat_res.last           = 1'b1;

        push = '0;
        if (hold_valid_reg)
        begin
            if (emit_body && hold_eor_reg)
            begin
                push.count  = 2'd2;
                push.first  = body_res;
                push.second = stat_res;
            end
            else if (emit_body)
            begin
                push.count = 2'd1;
                push.first = body_res;
            end
            else if (hold_eor_reg)
            begin
                push.count = 2'd1;
                push.first = stat_res;
            end
        end
    end

    // State update; everything returns to its reset value after a status word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            declared_reg   <= '0;
            code_reg       <= '0;
            txid_reg       <= '0;
            strip_reg      <= 1'b0;
            body_count_reg <= '0;
        end
        else if (hold_valid_reg)
        begin
            if (hold_eor_reg)
            begin
                byte_index_reg <= '0;
                declared_reg   <= '0;
                code_reg       <= '0;
                txid_reg       <= '0;
                strip_reg      <= 1'b0;
                body_count_reg <= '0;
            end
            else
            begin
                byte_index_reg <= byte_index_next;
                declared_reg   <= declared_next;
                code_reg       <= code_next;
                txid_reg       <= txid_next;
                strip_reg      <= strip_next;
                body_count_reg <= body_count_next;
            end
        end
    end

endmodule

// ===== design/rmd_queue.sv =====
// Result queue that takes up to two words per cycle and delivers one per cycle while pop is high.
// Depends on rmd_pkg; sits between rmd_parser and the output stream.
`timescale 1ns / 1ps

module rmd_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rmd_pkg::push_t              push,
    input  logic                        pop,
    output rmd_pkg::result_t            head,
    output logic                        not_empty,
    output logic [rmd_pkg::QLVL_W-1:0]  level
);

    localparam int unsigned QLVL_W = rmd_pkg::QLVL_W;

    rmd_pkg::result_t mem [rmd_pkg::QUEUE_DEPTH];

    logic [rmd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [rmd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [rmd_pkg::QLVL_W-1:0] level_reg, level_next;
    logic                       do_pop;

    assign not_empty = level_reg != '0;
    assign level     = level_reg;
    assign head      = mem[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        level_next = level_reg + QLVL_W'(push.count) - QLVL_W'(do_pop);
    end

    // Storage writes.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + rmd_pkg::QPTR_W'(1)] <= push.second;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + rmd_pkg::QPTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + rmd_pkg::QPTR_W'(do_pop);
            level_reg  <= level_next;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for rpc_message_deframer: drives device reads as byte words
// and checks every body and status word against an in-house deframing calculation.
// Depends on rmd_pkg and the rpc_message_deframer RTL.
`timescale 1ns / 1ps

// Tracks the header state of the read in progress and holds the words the block owes.
class deframe_tracker;
    rmd_pkg::result_t due_words[$];
    int unsigned mismatches;
    int unsigned words_seen;
    int unsigned read_limit;

    int unsigned byte_index;
    logic [31:0] declared_length;
    logic [31:0] code_word;
    logic [31:0] txid_word;
    int unsigned body_start;
    int unsigned body_count;

    function new(int unsigned limit);
        read_limit = limit;
        mismatches = 0;
        words_seen = 0;
        clear_read();
    endfunction

    // Every read starts from an empty header.
    function void clear_read();
        byte_index      = 0;
        declared_length = '0;
        code_word       = '0;
        txid_word       = '0;
        body_start      = rmd_pkg::HDR_BYTES;
        body_count      = 0;
    endfunction

    // A transaction word in the async range, other than the base itself.
    function bit async_txid();
        return txid_word != rmd_pkg::TXID_BASE
            && (txid_word & rmd_pkg::TXID_MASK) == rmd_pkg::TXID_BASE;
    endfunction

    function logic [1:0] message_class();
        if (txid_word == rmd_pkg::TXID_BASE)
            return rmd_pkg::MSG_RESPONSE;
        if (async_txid())
            return (code_word >= rmd_pkg::ACK_CODE_MIN) ? rmd_pkg::MSG_ASYNC_ACK
                                                        : rmd_pkg::MSG_RESPONSE;
        return rmd_pkg::MSG_UNSOLICITED;
    endfunction

    // Works out the words caused by one accepted byte.
    function void deframe_byte(logic [7:0] b, logic eor);
        rmd_pkg::result_t       word;
        longint unsigned        frame_size;
        logic [1:0]             st;
        if (byte_index < read_limit) begin
            if (byte_index < 4)
                declared_length[8 * byte_index +: 8] = b;
            else if (byte_index >= 12 && byte_index < 16)
                code_word = {code_word[23:0], b};
            else if (byte_index >= 16 && byte_index < rmd_pkg::HDR_BYTES)
                txid_word = {txid_word[23:0], b};
            frame_size = longint'(declared_length) + 4;

            // The prefix of an async response is only stripped when the body can hold it.
            if (byte_index == rmd_pkg::HDR_BYTES - 1) begin
                if (async_txid() && code_word < rmd_pkg::ACK_CODE_MIN
                        && frame_size >= rmd_pkg::HDR_BYTES + rmd_pkg::PREFIX_BYTES)
                    body_start = rmd_pkg::HDR_BYTES + rmd_pkg::PREFIX_BYTES;
                else
                    body_start = rmd_pkg::HDR_BYTES;
            end

            // Body bytes up to the declared size; padding after it is dropped.
            if (byte_index >= rmd_pkg::HDR_BYTES && byte_index >= body_start
                    && byte_index < frame_size) begin
                word = '0;
                word.item_kind = rmd_pkg::KIND_BODY;
                word.body_byte = b;
                due_words.push_back(word);
                body_count++;
            end
            byte_index++;
        end

        // The end of the read always yields one status word.
        if (eor) begin
            frame_size = longint'(declared_length) + 4;
            if (byte_index < rmd_pkg::HDR_BYTES)
                st = rmd_pkg::ST_SHORT;
            else if (frame_size < rmd_pkg::HDR_BYTES)
                st = rmd_pkg::ST_BAD_SIZE;
            else if (frame_size > byte_index)
                st = rmd_pkg::ST_TRUNCATED;
            else
                st = rmd_pkg::ST_OK;
            word = '0;
            word.item_kind   = rmd_pkg::KIND_STATUS;
            word.status      = st;
            word.body_length = body_count[14:0];
            word.last        = 1'b1;
            if (st == rmd_pkg::ST_OK) begin
                word.message_type   = message_class();
                word.message_code   = code_word;
                word.transaction_id = txid_word;
            end
            due_words.push_back(word);
            clear_read();
        end
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 40)
            $display("word %0d: %s is 0x%0h, expected 0x%0h", words_seen, what, got, want);
        mismatches++;
    endtask

    task compare_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Compares one accepted output word with the oldest word owed.
    task check_word(logic [95:0] data, logic kind, logic last);
        rmd_pkg::result_t want;
        if (due_words.size() == 0) begin
            report_mismatch("unexpected word, kind", {31'b0, kind}, '0);
        end
        else begin
            want = due_words.pop_front();
            compare_field("item_kind", {31'b0, kind}, {31'b0, want.item_kind});
            compare_field("body_byte", {24'b0, data[7:0]}, {24'b0, want.body_byte});
            compare_field("message_type", {30'b0, data[9:8]}, {30'b0, want.message_type});
            compare_field("message_code", data[41:10], want.message_code);
            compare_field("transaction_id", data[73:42], want.transaction_id);
            compare_field("status", {30'b0, data[75:74]}, {30'b0, want.status});
            compare_field("body_length", {17'b0, data[90:76]}, {17'b0, want.body_length});
            compare_field("unused bits", {27'b0, data[95:91]}, '0);
            compare_field("last", {31'b0, last}, {31'b0, want.last});
        end
        words_seen++;
    endtask
endclass

module tb_top;

    localparam int unsigned READ_LIMIT   = 16384;
    localparam int unsigned RANDOM_BYTES = 1530;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    logic        rx_hold  = 1'b0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int unsigned bytes_sent = 0;

    deframe_tracker tracker = new(READ_LIMIT);

    rpc_message_deframer #(
        .MAX_READ_BYTES(READ_LIMIT)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Offers one byte word after a random gap and waits until the block takes it.
    task send_byte(logic [7:0] b, logic eor);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eor;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.deframe_byte(b, eor);
        bytes_sent++;
    endtask

    // Sends one device read: length word, code and transaction word in their header
    // places, random bytes everywhere else.
    task send_read(logic [31:0] len_word, logic [31:0] code, logic [31:0] txid,
                   int unsigned read_len);
        logic [7:0] b;
        tx_burst = ($urandom_range(0, 3) == 0);
        for (int unsigned i = 0; i < read_len; i++)
        begin
            if (i < 4)
                b = len_word[8 * i +: 8];
            else if (i >= 12 && i < 16)
                b = code[8 * (15 - i) +: 8];
            else if (i >= 16 && i < rmd_pkg::HDR_BYTES)
                b = txid[8 * (19 - i) +: 8];
            else
                b = 8'($urandom_range(0, 255));
            send_byte(b, i == read_len - 1);
        end
    endtask

    function logic [31:0] pick_txid();
        case ($urandom_range(0, 4))
            0:       return rmd_pkg::TXID_BASE;
            1:       return rmd_pkg::TXID_BASE | 32'($urandom_range(0, 255));
            2:       return rmd_pkg::TXID_BASE | 32'hFF;
            3:       return rmd_pkg::TXID_BASE ^ (32'h1 << $urandom_range(8, 31));
            default: return $urandom;
        endcase
    endfunction

    function logic [31:0] pick_code();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, rmd_pkg::ACK_CODE_MIN - 1);
            1:       return rmd_pkg::ACK_CODE_MIN - $urandom_range(0, 1);
            2:       return $urandom_range(rmd_pkg::ACK_CODE_MIN, 70000);
            default: return $urandom;
        endcase
    endfunction

    // One random read: mostly well-formed messages, the rest broken in various ways.
    task send_random_read();
        int unsigned pick;
        int unsigned body;
        int unsigned frame_size;
        pick = $urandom_range(0, 99);
        body = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : $urandom_range(0, 40);
        frame_size = rmd_pkg::HDR_BYTES + body;
        if (pick < 70)
            send_read(frame_size - 4, pick_code(), pick_txid(),
                      frame_size + $urandom_range(0, 4));
        else if (pick < 80)
            send_read(frame_size + $urandom_range(1, 8) - 4, pick_code(), pick_txid(),
                      frame_size);
        else if (pick < 88)
            send_read($urandom, pick_code(), pick_txid(),
                      $urandom_range(1, rmd_pkg::HDR_BYTES - 1));
        else if (pick < 95)
            send_read($urandom_range(0, rmd_pkg::HDR_BYTES - 5), pick_code(), pick_txid(),
                      $urandom_range(rmd_pkg::HDR_BYTES, 40));
        else
            send_read($urandom, $urandom, $urandom, $urandom_range(1, 60));
    endtask

    // Receiver: waits a random number of cycles before each word, and holds off
    // entirely while the long stall is on.
    initial
    begin
        int unsigned wait_left;
        wait (rst_n === 1'b1);
        wait_left = $urandom_range(0, 5);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                tracker.check_word(m_tdata, m_tuser, m_tlast);
                if ($urandom_range(0, 63) == 0)
                    rx_burst = !rx_burst;
                wait_left = rx_burst ? 0 : $urandom_range(0, 5);
            end
            else if (wait_left > 0)
            begin
                wait_left--;
            end
            m_tready <= (wait_left == 0) && !rx_hold;
        end
    end

    // Long receiver stall in the middle of the random reads, so the result queue fills
    // and the input side backs up.
    initial
    begin
        wait (rst_n === 1'b1);
        repeat (1500) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Run limit well above the slowest correct run.
    initial
    begin
        #40_000_000;
        $display("rpc_message_deframer: mismatch");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        int unsigned random_end;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Short reads, implausible sizes and a plain response.
        send_read(32'h0, 32'h0, 32'h0, 1);
        send_read(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, rmd_pkg::HDR_BYTES - 1);
        send_read(32'h0, 32'h0, 32'h0, rmd_pkg::HDR_BYTES + 1);
        send_read(rmd_pkg::HDR_BYTES - 5, 32'd1, rmd_pkg::TXID_BASE, rmd_pkg::HDR_BYTES);
        send_read(rmd_pkg::HDR_BYTES - 4, 32'hFFFF_FFFF, rmd_pkg::TXID_BASE,
                  rmd_pkg::HDR_BYTES);
        // Async response with the prefix stripped, then with a body too short for it,
        // then with exactly the prefix.
        send_read(26, rmd_pkg::ACK_CODE_MIN - 1, 32'h1100_01AB, 39);
        send_read(21, 32'h0, 32'h1100_01FF, 25);
        send_read(22, 32'h0, 32'h1100_01FF, 26);
        send_read(20, rmd_pkg::ACK_CODE_MIN, 32'h1100_0101, 24);
        send_read(19, 32'd5, 32'h2200_0100, 23);
        // Truncated message, and a length word so large that the size must not wrap.
        send_read(26, 32'd7, rmd_pkg::TXID_BASE, 25);
        send_read(32'hFFFF_FFFF, 32'h0, rmd_pkg::TXID_BASE, 24);

        random_end = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < random_end)
            send_random_read();
        s_tvalid <= 1'b0;

        while (tracker.due_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("rpc_message_deframer: match");
        else
            $display("rpc_message_deframer: mismatch");
        $finish;
    end

endmodule
